>>> rtl/plcm_pkg.sv
`timescale 1ns / 1ps
package plcm_pkg;

  localparam int COORD_BITS = 16;
  localparam int TDATA_W    = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int NPTS       = 5;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one queued flush: an optional group of up to four points, then an
  // optional single point of a one-point group
  typedef struct packed {
    logic   has_group;
    coord_t key;
    coord_t first;
    coord_t vmin;
    coord_t vmax;
    coord_t latest;
    logic   has_extra;
    coord_t xkey;
    coord_t xval;
    logic   axis;
    logic   eos;
  } flush_t;

endpackage

>>> rtl/plcm_front.sv
`timescale 1ns / 1ps
module plcm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  group_axis,
  input  logic                  acc,
  input  plcm_pkg::coord_t      px,
  input  plcm_pkg::coord_t      py,
  input  logic                  is_last,
  output logic                  push,
  output plcm_pkg::flush_t      push_data
);

  logic             open_r, open_nxt;
  plcm_pkg::coord_t key_r, key_nxt;
  plcm_pkg::coord_t first_r, first_nxt;
  plcm_pkg::coord_t min_r, min_nxt;
  plcm_pkg::coord_t max_r, max_nxt;
  plcm_pkg::coord_t latest_r, latest_nxt;
  plcm_pkg::coord_t key, value;
  logic             same_key;

  assign key      = (group_axis == plcm_pkg::AXIS_Y) ? py : px;
  assign value    = (group_axis == plcm_pkg::AXIS_Y) ? px : py;
  assign same_key = open_r && (key == key_r);

  always_comb begin
    open_nxt   = open_r;
    key_nxt    = key_r;
    first_nxt  = first_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    latest_nxt = latest_r;
    push       = 1'b0;
    push_data  = '0;
    push_data.axis = group_axis;
    push_data.eos  = is_last;
    if (acc) begin
      if (same_key) begin
        if (value < min_r) begin
          min_nxt = value;
        end else if (value > max_r) begin
          max_nxt = value;
        end
        latest_nxt = value;
        if (is_last) begin
          push                = 1'b1;
          push_data.has_group = 1'b1;
          push_data.key       = key_r;
          push_data.first     = first_r;
          push_data.vmin      = min_nxt;
          push_data.vmax      = max_nxt;
          push_data.latest    = value;
        end
      end else begin
        if (open_r) begin
          push                = 1'b1;
          push_data.has_group = 1'b1;
          push_data.key       = key_r;
          push_data.first     = first_r;
          push_data.vmin      = min_r;
          push_data.vmax      = max_r;
          push_data.latest    = latest_r;
        end
        if (is_last) begin
          push                = 1'b1;
          push_data.has_extra = 1'b1;
          push_data.xkey      = key;
          push_data.xval      = value;
        end
        open_nxt   = 1'b1;
        key_nxt    = key;
        first_nxt  = value;
        min_nxt    = value;
        max_nxt    = value;
        latest_nxt = value;
      end
      if (is_last) begin
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    first_r  <= first_nxt;
    min_r    <= min_nxt;
    max_r    <= max_nxt;
    latest_r <= latest_nxt;
  end

endmodule

>>> rtl/plcm_fifo.sv
`timescale 1ns / 1ps
module plcm_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  plcm_pkg::flush_t wdata,
  input  logic             pop,
  output plcm_pkg::flush_t rdata,
  output logic             empty,
  output logic             full
);

  plcm_pkg::flush_t                 mem_r [plcm_pkg::FIFO_DEPTH];
  logic [plcm_pkg::PTR_W-1:0]       wptr_r, wptr_nxt;
  logic [plcm_pkg::PTR_W-1:0]       rptr_r, rptr_nxt;
  logic [plcm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == plcm_pkg::CNT_W'(plcm_pkg::FIFO_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == plcm_pkg::PTR_W'(plcm_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == plcm_pkg::PTR_W'(plcm_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/plcm_back.sv
`timescale 1ns / 1ps
module plcm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  plcm_pkg::flush_t              head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [plcm_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tlast,
  output logic                          out_tuser
);

  plcm_pkg::flush_t             cur_r;
  plcm_pkg::coord_t             near_r, far_r;
  logic [plcm_pkg::NPTS-1:0]    mask_r, mask_nxt, mask_clr, load_mask;
  plcm_pkg::coord_t             ld_near, ld_far;
  logic                         adv, emit;
  plcm_pkg::coord_t             sel_key, sel_val, pt_x, pt_y;
  logic                         ov_r, ov_nxt;
  logic [plcm_pkg::TDATA_W-1:0] od_r;
  logic                         ol_r, ou_r;

  assign adv      = !ov_r || out_tready;
  assign emit     = adv && (mask_r != '0);
  assign mask_clr = mask_r & (mask_r - 1'b1);
  assign pop      = !empty && ((mask_r == '0) || (emit && (mask_clr == '0)));

  always_comb begin
    if (head.latest > head.first) begin
      ld_near = head.vmin;
      ld_far  = head.vmax;
    end else begin
      ld_near = head.vmax;
      ld_far  = head.vmin;
    end
    load_mask[0] = head.has_group;
    load_mask[1] = head.has_group && (ld_near != head.first);
    load_mask[2] = head.has_group && (ld_far != ld_near);
    load_mask[3] = head.has_group && (head.latest != ld_far);
    load_mask[4] = head.has_extra;
  end

  always_comb begin
    sel_key = cur_r.key;
    if (mask_r[0]) begin
      sel_val = cur_r.first;
    end else if (mask_r[1]) begin
      sel_val = near_r;
    end else if (mask_r[2]) begin
      sel_val = far_r;
    end else if (mask_r[3]) begin
      sel_val = cur_r.latest;
    end else begin
      sel_key = cur_r.xkey;
      sel_val = cur_r.xval;
    end
    pt_x = (cur_r.axis == plcm_pkg::AXIS_Y) ? sel_val : sel_key;
    pt_y = (cur_r.axis == plcm_pkg::AXIS_Y) ? sel_key : sel_val;
  end

  always_comb begin
    mask_nxt = mask_r;
    if (emit) begin
      mask_nxt = mask_clr;
    end
    if (pop) begin
      mask_nxt = load_mask;
    end
    ov_nxt = ov_r;
    if (adv) begin
      ov_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= head;
      near_r <= ld_near;
      far_r  <= ld_far;
    end
    if (emit) begin
      od_r <= plcm_pkg::TDATA_W'({pt_y, pt_x});
      ol_r <= (mask_clr == '0);
      ou_r <= (mask_clr == '0) && cur_r.eos;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

endmodule

>>> rtl/polyline_column_minmax_reducer.sv
`timescale 1ns / 1ps
// Min/max polyline reducer. Points are grouped by equal x (cfg_wdata 0) or
// equal y (1); each closed group leaves as first, near extreme, far extreme
// and latest point with repeats dropped, and a point with in_tlast closes the
// series. An input transaction is taken every cycle while the four-entry
// flush queue has room; the output side emits one point per cycle while
// out_tready allows, and a flush holds n points (up to five for a last point
// that also changes the key). A flushed point passes through the flush queue,
// the back end's current-flush register and the output register before it
// appears on the output. out_tlast marks the final point caused by one input
// transaction, out_tuser the final point of the series.
module polyline_column_minmax_reducer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [plcm_pkg::TDATA_W-1:0]  in_tdata,   // x, y
  input  logic                          in_tlast,   // last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [plcm_pkg::TDATA_W-1:0]  out_tdata,  // out_x, out_y
  output logic                          out_tlast,  // last_of_run
  output logic                          out_tuser   // end_of_series
);

  logic             axis_r;
  logic             acc, push, pop, empty, full;
  plcm_pkg::flush_t push_data, head;
  plcm_pkg::coord_t px, py;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= plcm_pkg::AXIS_X;
    end else if (cfg_we) begin
      axis_r <= cfg_wdata;
    end
  end

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;
  assign px        = in_tdata[plcm_pkg::COORD_BITS-1:0];
  assign py        = in_tdata[2*plcm_pkg::COORD_BITS-1:plcm_pkg::COORD_BITS];

  plcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .group_axis (axis_r),
    .acc        (acc),
    .px         (px),
    .py         (py),
    .is_last    (in_tlast),
    .push       (push),
    .push_data  (push_data)
  );

  plcm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .rdata (head),
    .empty (empty),
    .full  (full)
  );

  plcm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> bench/tb_polyline_column_minmax_reducer.sv
`timescale 1ns / 1ps
module tb_polyline_column_minmax_reducer;

  typedef struct {
    plcm_pkg::coord_t px;
    plcm_pkg::coord_t py;
    logic             run_end;
    logic             series_end;
  } reduced_pt_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic                         cfg_wdata;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [plcm_pkg::TDATA_W-1:0] in_tdata;
  logic                         in_tlast;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [plcm_pkg::TDATA_W-1:0] out_tdata;
  logic                         out_tlast;
  logic                         out_tuser;

  // prediction state
  logic             axis_sel;
  logic             grp_open;
  plcm_pkg::coord_t grp_key;
  plcm_pkg::coord_t grp_first;
  plcm_pkg::coord_t grp_min;
  plcm_pkg::coord_t grp_max;
  plcm_pkg::coord_t grp_latest;
  reduced_pt_t      pending_pts[$];

  int  err_count;
  int  points_sent;
  int  series_done;
  int  results_seen;
  int  rx_hold;
  int  rx_stall_left;
  bit  tx_gaps_on;
  bit  rx_stalls_on;
  bit  axis_used[2];

  polyline_column_minmax_reducer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic plcm_pkg::coord_t pick_coord(int spread);
    case ($urandom_range(0, 9))
      0: return plcm_pkg::coord_t'(-32768);
      1: return plcm_pkg::coord_t'(32767);
      2, 3, 4: return plcm_pkg::coord_t'($urandom);
      default: return plcm_pkg::coord_t'($urandom_range(0, 2 * spread) - spread);
    endcase
  endfunction

  function automatic void queue_point(plcm_pkg::coord_t value);
    reduced_pt_t p;
    if (axis_sel == plcm_pkg::AXIS_Y) begin
      p.px = value;
      p.py = grp_key;
    end else begin
      p.px = grp_key;
      p.py = value;
    end
    p.run_end    = 1'b0;
    p.series_end = 1'b0;
    pending_pts.push_back(p);
  endfunction

  function automatic void close_group();
    plcm_pkg::coord_t near_ext;
    plcm_pkg::coord_t far_ext;
    near_ext = grp_max;
    far_ext  = grp_min;
    if (grp_latest > grp_first) begin
      near_ext = grp_min;
      far_ext  = grp_max;
    end
    queue_point(grp_first);
    if (near_ext != grp_first) queue_point(near_ext);
    if (far_ext != near_ext) queue_point(far_ext);
    if (grp_latest != far_ext) queue_point(grp_latest);
  endfunction

  function automatic void open_group(plcm_pkg::coord_t key, plcm_pkg::coord_t value);
    grp_open   = 1'b1;
    grp_key    = key;
    grp_first  = value;
    grp_min    = value;
    grp_max    = value;
    grp_latest = value;
  endfunction

  function automatic void reduce_point(plcm_pkg::coord_t x, plcm_pkg::coord_t y,
                                       logic last);
    plcm_pkg::coord_t key;
    plcm_pkg::coord_t value;
    int               n0;
    reduced_pt_t      p;
    key   = (axis_sel == plcm_pkg::AXIS_Y) ? y : x;
    value = (axis_sel == plcm_pkg::AXIS_Y) ? x : y;
    n0    = pending_pts.size();
    if (!grp_open) begin
      open_group(key, value);
    end else if (key == grp_key) begin
      if (value < grp_min) begin
        grp_min = value;
      end else if (value > grp_max) begin
        grp_max = value;
      end
      grp_latest = value;
    end else begin
      close_group();
      open_group(key, value);
    end
    if (last) begin
      close_group();
      grp_open = 1'b0;
    end
    if (pending_pts.size() > n0) begin
      p = pending_pts.pop_back();
      p.run_end    = 1'b1;
      p.series_end = last;
      pending_pts.push_back(p);
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_point(plcm_pkg::coord_t x, plcm_pkg::coord_t y, logic last);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    reduce_point(x, y, last);
    points_sent++;
    if (last) series_done++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pts.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_axis(logic a);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    axis_sel = a;
    axis_used[a] = 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string fname, int expv, int actv);
    if (expv != actv) begin
      $display("%0t: %s expected %0d, got %0d", $time, fname, expv, actv);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    reduced_pt_t      exp_pt;
    plcm_pkg::coord_t act_x;
    plcm_pkg::coord_t act_y;
    if (rst_n && out_tvalid && out_tready) begin
      act_x = out_tdata[plcm_pkg::COORD_BITS-1:0];
      act_y = out_tdata[2*plcm_pkg::COORD_BITS-1:plcm_pkg::COORD_BITS];
      results_seen++;
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got x=%0d y=%0d",
                 $time, act_x, act_y);
        err_count++;
      end else begin
        exp_pt = pending_pts.pop_front();
        check_field("out_x", exp_pt.px, act_x);
        check_field("out_y", exp_pt.py, act_y);
        check_field("last_of_run", exp_pt.run_end, out_tlast);
        check_field("end_of_series", exp_pt.series_end, out_tuser);
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    rx_stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (!rx_stalls_on) begin
        out_tready <= 1'b1;
      end else if (rx_stall_left > 0) begin
        out_tready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_tready <= 1'b1;
        rx_stall_left = pick_gap();
      end
    end
  end

  task automatic test_single_point_series();
    send_point(plcm_pkg::coord_t'(-32768), plcm_pkg::coord_t'(32767), 1'b1);
    send_point(plcm_pkg::coord_t'(32767), plcm_pkg::coord_t'(-32768), 1'b1);
    send_point(plcm_pkg::coord_t'(0), plcm_pkg::coord_t'(-1), 1'b1);
  endtask

  task automatic test_rising_group();
    send_point(plcm_pkg::coord_t'(5), plcm_pkg::coord_t'(10), 1'b0);
    send_point(plcm_pkg::coord_t'(5), plcm_pkg::coord_t'(3), 1'b0);
    send_point(plcm_pkg::coord_t'(5), plcm_pkg::coord_t'(20), 1'b0);
    send_point(plcm_pkg::coord_t'(5), plcm_pkg::coord_t'(15), 1'b0);
    send_point(plcm_pkg::coord_t'(6), plcm_pkg::coord_t'(0), 1'b0);
    send_point(plcm_pkg::coord_t'(6), plcm_pkg::coord_t'(0), 1'b1);
  endtask

  // key change on the last point: four from the old group plus one
  task automatic test_falling_group_last_key_change();
    send_point(plcm_pkg::coord_t'(-1), plcm_pkg::coord_t'(0), 1'b0);
    send_point(plcm_pkg::coord_t'(-1), plcm_pkg::coord_t'(40), 1'b0);
    send_point(plcm_pkg::coord_t'(-1), plcm_pkg::coord_t'(-7), 1'b0);
    send_point(plcm_pkg::coord_t'(-1), plcm_pkg::coord_t'(-2), 1'b0);
    send_point(plcm_pkg::coord_t'(-32768), plcm_pkg::coord_t'(32767), 1'b1);
  endtask

  task automatic test_repeated_values();
    send_point(plcm_pkg::coord_t'(32767), plcm_pkg::coord_t'(32767), 1'b0);
    send_point(plcm_pkg::coord_t'(32767), plcm_pkg::coord_t'(32767), 1'b0);
    send_point(plcm_pkg::coord_t'(32767), plcm_pkg::coord_t'(32767), 1'b1);
  endtask

  // group left open across an axis change
  task automatic test_axis_switch_open_group();
    send_point(plcm_pkg::coord_t'(100), plcm_pkg::coord_t'(1), 1'b0);
    send_point(plcm_pkg::coord_t'(100), plcm_pkg::coord_t'(2), 1'b0);
    set_axis(plcm_pkg::AXIS_Y);
    send_point(plcm_pkg::coord_t'(7), plcm_pkg::coord_t'(100), 1'b0);
    send_point(plcm_pkg::coord_t'(8), plcm_pkg::coord_t'(50), 1'b1);
    set_axis(plcm_pkg::AXIS_X);
  endtask

  task automatic test_random_series(int n_points, logic a);
    int               sent;
    int               n_groups;
    int               glen;
    plcm_pkg::coord_t key;
    plcm_pkg::coord_t value;
    logic             last;
    set_axis(a);
    sent = 0;
    while (sent < n_points) begin
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      n_groups = $urandom_range(1, 8);
      for (int g = 0; g < n_groups; g++) begin
        key  = pick_coord(3);
        glen = $urandom_range(1, 6);
        for (int i = 0; i < glen; i++) begin
          value = pick_coord(5);
          last  = (g == n_groups - 1) && (i == glen - 1);
          if (a == plcm_pkg::AXIS_Y) begin
            send_point(value, key, last);
          end else begin
            send_point(key, value, last);
          end
          sent++;
        end
      end
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering key changes
  task automatic test_output_backpressure();
    wait_idle();
    @(negedge clk);
    tx_gaps_on = 1'b0;
    rx_hold    = 150;
    for (int i = 0; i < 24; i++) begin
      send_point(pick_coord(40), pick_coord(40), i == 23);
    end
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    axis_sel     = plcm_pkg::AXIS_X;
    grp_open     = 1'b0;
    grp_key      = '0;
    grp_first    = '0;
    grp_min      = '0;
    grp_max      = '0;
    grp_latest   = '0;
    err_count    = 0;
    points_sent  = 0;
    series_done  = 0;
    results_seen = 0;
    rx_hold      = 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    axis_used[plcm_pkg::AXIS_X] = 1'b1;
    axis_used[plcm_pkg::AXIS_Y] = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_point_series();
    test_rising_group();
    test_falling_group_last_key_change();
    test_repeated_values();
    test_axis_switch_open_group();
    test_random_series(130, plcm_pkg::AXIS_X);
    test_random_series(130, plcm_pkg::AXIS_Y);
    test_output_backpressure();
    test_random_series(40, plcm_pkg::AXIS_X);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Run covered %0d points in %0d series, %0d reduced points checked.",
             points_sent, series_done, results_seen);
    $display("Grouping by x used: %0d, by y used: %0d; one long output hold-off.",
             axis_used[plcm_pkg::AXIS_X], axis_used[plcm_pkg::AXIS_Y]);
    if (err_count == 0 && pending_pts.size() == 0) begin
      $display("polyline_column_minmax_reducer: match");
    end else begin
      $display("polyline_column_minmax_reducer: mismatch");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timeout with %0d results outstanding", pending_pts.size());
    $display("polyline_column_minmax_reducer: mismatch");
    $finish;
  end

endmodule
